@@ hw/rtl/bclh_pkg.sv @@
// bclh_pkg: shared types and codes for the button click / long hold classifier
// holds item structs, function and event codes, register indexes and reset values
// no dependencies
package bclh_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_EDGE = 2'd1,
    FUNC_POLL = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_EJECT = 2'd3
  } event_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KEY_PIN_MASK  = 2'd0,
    REG_DEBOUNCE_MS   = 2'd1,
    REG_LONG_PRESS_MS = 2'd2,
    REG_EJECT_HOLD_MS = 2'd3
  } reg_index_t;

  // register reset values
  localparam logic [CFG_DATA_WIDTH-1:0] KEY_PIN_MASK_RESET  = 16'd1;
  localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_MS_RESET   = 16'd30;
  localparam logic [CFG_DATA_WIDTH-1:0] LONG_PRESS_MS_RESET = 16'd700;
  localparam logic [CFG_DATA_WIDTH-1:0] EJECT_HOLD_MS_RESET = 16'd3000;

  // input item
  typedef struct packed {
    func_t       func;
    logic [15:0] pin_mask;
    logic        pin_level;
  } in_item_t;

  // result item
  typedef struct packed {
    event_t taken_event;
    event_t pending_code;
    logic   key_held;
    logic   edge_accepted;
  } out_item_t;

endpackage

@@ hw/rtl/bclh_stream_if.sv @@
// bclh_stream_if: valid/ready channel carrying one item per handshake
// item type is a parameter; used with the structs of bclh_pkg
// no dependencies
interface bclh_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/button_click_long_hold_classifier_unit.sv @@
// button_click_long_hold_classifier_unit: top level of the button classifier
// depends on bclh_pkg and bclh_stream_if
//
// Each input item (millisecond tick, key pin edge, poll of the held key, or
// read of the pending event) produces exactly one result item, registered in
// the cycle after it is accepted. The block takes one item per clock; the only
// limit is the result register, which frees as soon as the sink takes its item,
// so in_ch.ready stays high while out_ch.ready is high. Time is a wrapping
// TIME_WIDTH-bit millisecond count and all hold and debounce durations are
// taken modulo 2^TIME_WIDTH. The user must write configuration registers
// only while the block is idle, via cfg_we / cfg_index / cfg_data; unenforced.
module button_click_long_hold_classifier_unit
  import bclh_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  bclh_stream_if.sink                in_ch,
  bclh_stream_if.source              out_ch
);

  // configuration registers
  logic [CFG_DATA_WIDTH-1:0] key_pin_mask;
  logic [CFG_DATA_WIDTH-1:0] debounce_ms;
  logic [CFG_DATA_WIDTH-1:0] long_press_ms;
  logic [CFG_DATA_WIDTH-1:0] eject_hold_ms;

  // classifier state
  logic [TIME_WIDTH-1:0] now_ms, now_ms_next;
  logic [TIME_WIDTH-1:0] last_edge_ms, last_edge_ms_next;
  logic [TIME_WIDTH-1:0] press_start_ms, press_start_ms_next;
  logic                  held_flag, held_flag_next;
  logic                  long_reported, long_reported_next;
  logic                  eject_reported, eject_reported_next;
  event_t                pending_event, pending_event_next;

  // result register
  logic      result_valid;
  out_item_t result;
  out_item_t result_next;

  logic in_fire;
  logic [TIME_WIDTH-1:0] since_edge;
  logic [TIME_WIDTH-1:0] hold_time;
  logic debounce_ok;
  logic long_due;
  logic eject_due;
  logic edge_ok;
  in_item_t item;

  // accept while the result register is empty or being drained
  assign in_ch.ready  = !result_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign item         = in_ch.data;
  assign out_ch.valid = result_valid;
  assign out_ch.data  = result;

  // elapsed times and threshold compares
  assign since_edge  = now_ms - last_edge_ms;
  assign hold_time   = now_ms - press_start_ms;
  assign debounce_ok = since_edge >= TIME_WIDTH'(debounce_ms);
  assign long_due    = hold_time >= TIME_WIDTH'(long_press_ms);
  assign eject_due   = hold_time >= TIME_WIDTH'(eject_hold_ms);
  assign edge_ok     = (item.pin_mask == key_pin_mask) && debounce_ok;

  // next state and result for the item at the input
  always_comb begin
    now_ms_next         = now_ms;
    last_edge_ms_next   = last_edge_ms;
    press_start_ms_next = press_start_ms;
    held_flag_next      = held_flag;
    long_reported_next  = long_reported;
    eject_reported_next = eject_reported;
    pending_event_next  = pending_event;
    result_next.taken_event   = EV_NONE;
    result_next.edge_accepted = 1'b0;

    unique case (item.func)
      FUNC_TICK: begin
        now_ms_next = now_ms + TIME_WIDTH'(1);
      end
      FUNC_EDGE: begin
        if (edge_ok) begin
          result_next.edge_accepted = 1'b1;
          last_edge_ms_next = now_ms;
          if (item.pin_level) begin
            // press: start timing a new hold
            held_flag_next      = 1'b1;
            press_start_ms_next = now_ms;
            long_reported_next  = 1'b0;
            eject_reported_next = 1'b0;
          end else if (held_flag) begin
            // release: classify the hold
            held_flag_next = 1'b0;
            priority if (eject_due && !eject_reported) begin
              eject_reported_next = 1'b1;
              long_reported_next  = 1'b1;
              pending_event_next  = EV_EJECT;
            end else if (long_due && !long_reported && pending_event == EV_NONE) begin
              long_reported_next = 1'b1;
              pending_event_next = EV_LONG;
            end else if (!long_reported && pending_event == EV_NONE) begin
              pending_event_next = EV_CLICK;
            end else begin
              pending_event_next = pending_event;
            end
          end
        end
      end
      FUNC_POLL: begin
        // raise events while the key is still held
        if (held_flag && pending_event == EV_NONE) begin
          priority if (!eject_reported && eject_due) begin
            eject_reported_next = 1'b1;
            long_reported_next  = 1'b1;
            pending_event_next  = EV_EJECT;
          end else if (!long_reported && long_due) begin
            long_reported_next = 1'b1;
            pending_event_next = EV_LONG;
          end else begin
            pending_event_next = pending_event;
          end
        end
      end
      FUNC_READ: begin
        result_next.taken_event = pending_event;
        pending_event_next      = EV_NONE;
      end
      default: begin
        now_ms_next = now_ms;
      end
    endcase

    result_next.pending_code = pending_event_next;
    result_next.key_held     = held_flag_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pin_mask  <= KEY_PIN_MASK_RESET;
      debounce_ms   <= DEBOUNCE_MS_RESET;
      long_press_ms <= LONG_PRESS_MS_RESET;
      eject_hold_ms <= EJECT_HOLD_MS_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_PIN_MASK:  key_pin_mask  <= cfg_data;
        REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data;
        REG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        REG_EJECT_HOLD_MS: eject_hold_ms <= cfg_data;
        default:           key_pin_mask  <= key_pin_mask;
      endcase
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      last_edge_ms   <= '0;
      press_start_ms <= '0;
      held_flag      <= 1'b0;
      long_reported  <= 1'b0;
      eject_reported <= 1'b0;
      pending_event  <= EV_NONE;
    end else if (in_fire) begin
      now_ms         <= now_ms_next;
      last_edge_ms   <= last_edge_ms_next;
      press_start_ms <= press_start_ms_next;
      held_flag      <= held_flag_next;
      long_reported  <= long_reported_next;
      eject_reported <= eject_reported_next;
      pending_event  <= pending_event_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_fire) begin
      result_valid <= 1'b1;
    end else if (out_ch.ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for button_click_long_hold_classifier_unit
// drives ticks, pin edges, polls and reads; checks every result against a hold tracker
// depends on bclh_pkg, bclh_stream_if and the classifier top level
module testbench;
  import bclh_pkg::*;

  // narrowest time base the block supports
  localparam int unsigned TW = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_CAP = 150;

  // mirror of the classifier: config, time, hold flags and the results owed
  class hold_tracker;
    logic [15:0]   key_mask;
    logic [15:0]   debounce;
    logic [15:0]   long_ms;
    logic [15:0]   eject_ms;
    logic [TW-1:0] now_ms;
    logic [TW-1:0] last_edge;
    logic [TW-1:0] press_start;
    bit            held;
    bit            long_done;
    bit            eject_done;
    event_t        pending;
    out_item_t     owed[$];
    int unsigned   fail_count;
    int unsigned   compared;
    int unsigned   edges_taken;
    int unsigned   reads_of[4];

    function new();
      key_mask    = KEY_PIN_MASK_RESET;
      debounce    = DEBOUNCE_MS_RESET;
      long_ms     = LONG_PRESS_MS_RESET;
      eject_ms    = EJECT_HOLD_MS_RESET;
      now_ms      = '0;
      last_edge   = '0;
      press_start = '0;
      held        = 1'b0;
      long_done   = 1'b0;
      eject_done  = 1'b0;
      pending     = EV_NONE;
      fail_count  = 0;
      compared    = 0;
      edges_taken = 0;
      foreach (reads_of[i]) reads_of[i] = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [15:0] val);
      case (idx)
        REG_KEY_PIN_MASK:  key_mask = val;
        REG_DEBOUNCE_MS:   debounce = val;
        REG_LONG_PRESS_MS: long_ms  = val;
        REG_EJECT_HOLD_MS: eject_ms = val;
        default: ;
      endcase
    endfunction

    // matched, debounced edge: press arms the hold, release classifies it
    function bit take_edge(logic [15:0] mask, logic level);
      logic [TW-1:0] span;
      if (mask != key_mask) return 1'b0;
      span = now_ms - last_edge;
      if (span < debounce) return 1'b0;
      last_edge = now_ms;
      if (level) begin
        held        = 1'b1;
        press_start = now_ms;
        long_done   = 1'b0;
        eject_done  = 1'b0;
        return 1'b1;
      end
      if (held) begin
        held = 1'b0;
        span = now_ms - press_start;
        // eject overrides whatever is pending
        if (span >= eject_ms && !eject_done) begin
          eject_done = 1'b1;
          long_done  = 1'b1;
          pending    = EV_EJECT;
        end else if (span >= long_ms && !long_done && pending == EV_NONE) begin
          long_done = 1'b1;
          pending   = EV_LONG;
        end else if (!long_done && pending == EV_NONE) begin
          pending = EV_CLICK;
        end
      end
      return 1'b1;
    endfunction

    // poll while held raises eject first, then long, only into an empty slot
    function void poll_hold();
      logic [TW-1:0] span;
      if (!held) return;
      span = now_ms - press_start;
      if (!eject_done && span >= eject_ms && pending == EV_NONE) begin
        eject_done = 1'b1;
        long_done  = 1'b1;
        pending    = EV_EJECT;
        return;
      end
      if (!long_done && span >= long_ms && pending == EV_NONE) begin
        long_done = 1'b1;
        pending   = EV_LONG;
      end
    endfunction

    function void take_item(in_item_t it);
      out_item_t r;
      r = '0;
      r.taken_event = EV_NONE;
      case (it.func)
        FUNC_TICK: now_ms = now_ms + TW'(1);
        FUNC_EDGE: begin
          r.edge_accepted = take_edge(it.pin_mask, it.pin_level);
          if (r.edge_accepted) edges_taken++;
        end
        FUNC_POLL: poll_hold();
        default: begin
          r.taken_event = pending;
          reads_of[pending]++;
          pending = EV_NONE;
        end
      endcase
      r.pending_code = pending;
      r.key_held     = held;
      owed.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with nothing owed: %p", $realtime, got);
        return;
      end
      want = owed.pop_front();
      compared++;
      if (got.taken_event !== want.taken_event || got.pending_code !== want.pending_code ||
          got.key_held !== want.key_held || got.edge_accepted !== want.edge_accepted) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;
  int unsigned                gap_pct;
  int unsigned                stall_pct;
  int unsigned                items_sent;
  int unsigned                settings_used;
  int unsigned                cycle_count;
  hold_tracker                tracker;

  bclh_stream_if #(.item_t(in_item_t))  in_if ();
  bclh_stream_if #(.item_t(out_item_t)) out_if ();

  button_click_long_hold_classifier_unit #(
    .TIME_WIDTH(TW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) tracker.check_result(out_if.data);
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) tracker.take_item(in_if.data);
    end
  end

  // one item, with random sender gaps; called and returns at a falling edge
  task automatic send_item(func_t f, logic [15:0] mask, logic level);
    in_item_t it;
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    it.func = f;
    if (f == FUNC_EDGE) begin
      it.pin_mask  = mask;
      it.pin_level = level;
    end else begin
      it.pin_mask  = 16'($urandom_range(16'hFFFF));
      it.pin_level = 1'($urandom_range(1));
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick();
    send_item(FUNC_TICK, '0, 1'b0);
  endtask

  // hold off input until every owed result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_setting(logic [15:0] mask, logic [15:0] deb, logic [15:0] lng,
                              logic [15:0] ej);
    write_reg(REG_KEY_PIN_MASK, mask);
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_LONG_PRESS_MS, lng);
    write_reg(REG_EJECT_HOLD_MS, ej);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned clip(int unsigned v);
    return (v > HOLD_CAP) ? HOLD_CAP : v;
  endfunction

  // settle, press, hold with polls and bounces, release, read back
  task automatic press_sequence();
    int unsigned settle;
    int unsigned hold_len;
    int unsigned top;
    logic [15:0] km;
    km     = tracker.key_mask;
    settle = $urandom_range(clip(tracker.debounce + 2));
    repeat (settle) begin
      tick();
      if ($urandom_range(99) < 8) send_item(FUNC_EDGE, km, 1'($urandom_range(1)));
    end
    send_item(FUNC_EDGE, ($urandom_range(99) < 10) ? 16'($urandom_range(16'hFFFF)) : km, 1'b1);
    top = 32'((tracker.long_ms > tracker.eject_ms) ? tracker.long_ms : tracker.eject_ms);
    hold_len = $urandom_range(clip(top + top / 2 + 4));
    repeat (hold_len) begin
      tick();
      if ($urandom_range(99) < 30) send_item(FUNC_POLL, '0, 1'b0);
      if ($urandom_range(99) < 5) send_item(FUNC_READ, '0, 1'b0);
      if ($urandom_range(99) < 4) send_item(FUNC_EDGE, km, 1'($urandom_range(1)));
    end
    if ($urandom_range(99) < 20) send_item(FUNC_POLL, '0, 1'b0);
    send_item(FUNC_EDGE, ($urandom_range(99) < 10) ? 16'($urandom_range(16'hFFFF)) : km, 1'b0);
    repeat ($urandom_range(2)) send_item(FUNC_READ, '0, 1'b0);
  endtask

  // unstructured items, edges half the time on the key pin
  task automatic noise_item();
    logic [15:0] mask;
    mask = ($urandom_range(1) != 0) ? tracker.key_mask : 16'($urandom_range(16'hFFFF));
    send_item(func_t'($urandom_range(3)), mask, 1'($urandom_range(1)));
  endtask

  task automatic run_phase(logic [15:0] mask, logic [15:0] deb, logic [15:0] lng,
                           logic [15:0] ej, int unsigned gap, int unsigned stall);
    int unsigned start;
    drain_results();
    load_setting(mask, deb, lng, ej);
    gap_pct   = gap;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(99) < 85) press_sequence();
      else repeat ($urandom_range(1, 6)) noise_item();
      if ($urandom_range(99) < 5) drain_results();
    end
  endtask

  // directed opening: debounce, mask mismatch, lone release, eject replacing long
  task automatic directed_items();
    send_item(FUNC_READ, '0, 1'b0);
    send_item(FUNC_POLL, '0, 1'b0);
    send_item(FUNC_EDGE, 16'h0001, 1'b1);
    tick();
    drain_results();
    load_setting(16'hFFFF, 16'd1, 16'd1, 16'd2);
    send_item(FUNC_EDGE, 16'h0000, 1'b1);
    send_item(FUNC_EDGE, 16'hFFFF, 1'b0);
    send_item(FUNC_EDGE, 16'hFFFF, 1'b1);
    tick();
    send_item(FUNC_EDGE, 16'hFFFF, 1'b1);
    tick();
    send_item(FUNC_POLL, '0, 1'b0);
    tick();
    send_item(FUNC_EDGE, 16'hFFFF, 1'b0);
    send_item(FUNC_READ, '0, 1'b0);
    send_item(FUNC_READ, '0, 1'b0);
    tick();
    send_item(FUNC_EDGE, 16'hFFFF, 1'b1);
    tick();
    tick();
    send_item(FUNC_POLL, '0, 1'b0);
    tick();
    send_item(FUNC_EDGE, 16'hFFFF, 1'b0);
    send_item(FUNC_READ, '0, 1'b0);
  endtask

  // stimulus
  initial begin
    logic [15:0] rlong;
    tracker       = new();
    items_sent    = 0;
    settings_used = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_KEY_PIN_MASK;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_items();

    // a few short presses on a high pin
    drain_results();
    load_setting(16'h4000, 16'd3, 16'd6, 16'd15);
    repeat (4) press_sequence();

    run_phase(16'hA5C3, 16'd0, 16'd0, 16'd0, 0, 0);
    rlong = 16'($urandom_range(1, 25));
    run_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(6)), rlong,
              rlong + 16'($urandom_range(30)), 75, 0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 75);
    run_phase(16'h0000, 16'd3, 16'd8, 16'd8, 27, 27);
    run_phase(16'h0001, 16'd1, 16'd30, 16'd10, 0, 0);
    rlong = 16'($urandom_range(1, 25));
    run_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(6)), rlong,
              rlong + 16'($urandom_range(30)), 75, 0);
    rlong = 16'($urandom_range(1, 25));
    run_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(6)), rlong,
              rlong + 16'($urandom_range(30)), 0, 75);
    rlong = 16'($urandom_range(1, 25));
    run_phase(16'($urandom_range(16'hFFFF)), 16'($urandom_range(6)), rlong,
              rlong + 16'($urandom_range(30)), 27, 27);

    // wind down
    drain_results();
    repeat (4) @(negedge clk);
    $display("coverage: %0d items under %0d register settings, %0d results compared",
             items_sent, settings_used, tracker.compared);
    $display("reads returned click %0d, long %0d, eject %0d; %0d edges taken; %0d failures",
             tracker.reads_of[EV_CLICK], tracker.reads_of[EV_LONG],
             tracker.reads_of[EV_EJECT], tracker.edges_taken, tracker.fail_count);
    if (tracker.fail_count == 0 && tracker.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
